// ----- rtl/ldws_pkg.sv -----
// ldws_pkg: shared types, constants and fixed-point helpers for the
// double-well Langevin step datapath
// depends on nothing
`default_nettype none

package ldws_pkg;

    // fixed-point format
    localparam int FRACTION_BITS = 24;
    localparam int DATA_W        = 32;
    localparam int UDATA_W       = 31;
    localparam int PROD_W        = 64;
    localparam int CFG_IDX_W     = 3;

    // latency from accepted request to result strobe
    localparam int PIPE_DEPTH    = 9;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_SCALE = 3'd0,
        CFG_INV_LENGTH  = 3'd1,
        CFG_ASYMMETRY   = 3'd2,
        CFG_TIME_STEP   = 3'd3,
        CFG_NOISE_SCALE = 3'd4,
        CFG_LOWER_BOUND = 3'd5,
        CFG_UPPER_BOUND = 3'd6
    } t_cfg_reg;

    // reset values, round to nearest of the real value
    localparam longint ONE_Q       = longint'(1) << FRACTION_BITS;
    localparam logic [UDATA_W-1:0] RST_DEPTH_SCALE = UDATA_W'(6 * ONE_Q);
    localparam logic [UDATA_W-1:0] RST_INV_LENGTH  = UDATA_W'(ONE_Q);
    localparam logic signed [DATA_W-1:0] RST_ASYMMETRY = DATA_W'((8 * ONE_Q + 5) / 10);
    localparam logic [UDATA_W-1:0] RST_TIME_STEP   = UDATA_W'((ONE_Q + 500) / 1000);
    localparam logic [UDATA_W-1:0] RST_NOISE_SCALE = '0;
    localparam logic signed [DATA_W-1:0] RST_LOWER_BOUND = DATA_W'(-3 * ONE_Q);
    localparam logic signed [DATA_W-1:0] RST_UPPER_BOUND = DATA_W'(3 * ONE_Q);

    localparam logic signed [PROD_W-1:0] SAT_MAX  = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_MIN  = -64'sd2147483648;
    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        PROD_W'(longint'(1) << (FRACTION_BITS - 1));

    // clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // scale a full product back to Q format: add half, floor, clamp
    function automatic logic signed [DATA_W-1:0] qscale(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + ROUND_HALF;
        return sat32(t >>> FRACTION_BITS);
    endfunction

    // signed by unsigned 31-bit product
    function automatic logic signed [PROD_W-1:0] mul_su(
        input logic signed [DATA_W-1:0]  a,
        input logic        [UDATA_W-1:0] b
    );
        logic signed [PROD_W-1:0] ax;
        logic signed [PROD_W-1:0] bx;
        ax = PROD_W'(a);
        bx = PROD_W'($signed({1'b0, b}));
        return ax * bx;
    endfunction

    // signed by signed product
    function automatic logic signed [PROD_W-1:0] mul_ss(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [PROD_W-1:0] ax;
        logic signed [PROD_W-1:0] bx;
        ax = PROD_W'(a);
        bx = PROD_W'(b);
        return ax * bx;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/langevin_double_well_step.sv -----
// langevin_double_well_step: one Euler-Maruyama step of an overdamped particle
// in a tilted quartic double well, nine-stage pipeline
// depends on ldws_pkg
//
// A request (position, noise sample) is taken at every clock edge where start
// is high; busy never rises, so one request per cycle is sustained. Each
// result appears on o_new_position for exactly one cycle with o_valid high,
// in request order; the receiver cannot stall the block and must take every
// result. The pipeline depth is set by the chain of six
// dependent products (x*inv_length, u^2, u^3, depth*g, s*inv_length,
// force*dt), each given its own registered stage, plus the cubic difference,
// the final sum and the wall reflection. Configuration writes are always ready
// and take effect at once; change registers only while no request is in flight.
`default_nettype none

module langevin_double_well_step
    import ldws_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request side
    input  wire logic                        start,
    output      logic                        busy,
    input  wire logic signed [DATA_W-1:0]    i_position,
    input  wire logic signed [DATA_W-1:0]    i_noise_sample,
    // result side
    output      logic                        o_valid,
    output      logic signed [DATA_W-1:0]    o_new_position,
    // configuration write channel
    input  wire logic                        i_cfg_valid,
    output      logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [DATA_W-1:0]           i_cfg_data
);

    // configuration registers
    logic        [UDATA_W-1:0] r_depth_scale;
    logic        [UDATA_W-1:0] r_inv_length;
    logic signed [DATA_W-1:0]  r_asymmetry;
    logic        [UDATA_W-1:0] r_time_step;
    logic        [UDATA_W-1:0] r_noise_scale;
    logic signed [DATA_W-1:0]  r_lower_bound;
    logic signed [DATA_W-1:0]  r_upper_bound;

    logic accept;
    logic cfg_wr;
    logic [PIPE_DEPTH:1] r_vld;

    // stage payload registers
    logic signed [PROD_W-1:0] r_s1_pu;
    logic signed [PROD_W-1:0] r_s1_pk;
    logic signed [DATA_W-1:0] r_s1_x;

    logic signed [PROD_W-1:0] r_s2_pu2;
    logic signed [DATA_W-1:0] r_s2_u;
    logic signed [DATA_W-1:0] r_s2_kick;
    logic signed [DATA_W-1:0] r_s2_x;

    logic signed [PROD_W-1:0] r_s3_pu3;
    logic signed [DATA_W-1:0] r_s3_u;
    logic signed [DATA_W-1:0] r_s3_kick;
    logic signed [DATA_W-1:0] r_s3_x;

    logic signed [DATA_W-1:0] r_s4_g;
    logic signed [DATA_W-1:0] r_s4_kick;
    logic signed [DATA_W-1:0] r_s4_x;

    logic signed [PROD_W-1:0] r_s5_pp;
    logic signed [DATA_W-1:0] r_s5_kick;
    logic signed [DATA_W-1:0] r_s5_x;

    logic signed [PROD_W-1:0] r_s6_pq;
    logic signed [DATA_W-1:0] r_s6_kick;
    logic signed [DATA_W-1:0] r_s6_x;

    logic signed [PROD_W-1:0] r_s7_pd;
    logic signed [DATA_W-1:0] r_s7_kick;
    logic signed [DATA_W-1:0] r_s7_x;

    logic signed [DATA_W+1:0] r_s8_y;
    logic signed [DATA_W-1:0] r_s9_out;

    // combinational stage results
    logic signed [DATA_W-1:0] s2_u;
    logic signed [DATA_W-1:0] s3_u2;
    logic signed [DATA_W-1:0] s4_u3;
    logic signed [DATA_W+2:0] s4_gdiff;
    logic signed [DATA_W-1:0] s6_p;
    logic signed [DATA_W:0]   s6_ssum;
    logic signed [DATA_W-1:0] s6_s;
    logic signed [DATA_W-1:0] s7_q;
    logic signed [DATA_W:0]   s7_neg;
    logic signed [DATA_W-1:0] s7_f;
    logic signed [DATA_W-1:0] s8_drift;
    logic signed [DATA_W+4:0] s9_y0;
    logic signed [DATA_W+4:0] s9_lo;
    logic signed [DATA_W+4:0] s9_hi;
    logic signed [DATA_W+4:0] s9_y1;
    logic signed [DATA_W+4:0] s9_y2;

    // handshakes: never busy, config always ready
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_scale <= RST_DEPTH_SCALE;
            r_inv_length  <= RST_INV_LENGTH;
            r_asymmetry   <= RST_ASYMMETRY;
            r_time_step   <= RST_TIME_STEP;
            r_noise_scale <= RST_NOISE_SCALE;
            r_lower_bound <= RST_LOWER_BOUND;
            r_upper_bound <= RST_UPPER_BOUND;
        end else if (cfg_wr) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_DEPTH_SCALE: r_depth_scale <= i_cfg_data[UDATA_W-1:0];
                CFG_INV_LENGTH:  r_inv_length  <= i_cfg_data[UDATA_W-1:0];
                CFG_ASYMMETRY:   r_asymmetry   <= $signed(i_cfg_data);
                CFG_TIME_STEP:   r_time_step   <= i_cfg_data[UDATA_W-1:0];
                CFG_NOISE_SCALE: r_noise_scale <= i_cfg_data[UDATA_W-1:0];
                CFG_LOWER_BOUND: r_lower_bound <= $signed(i_cfg_data);
                CFG_UPPER_BOUND: r_upper_bound <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-1:1], accept};
        end
    end

    // stages 2 to 4: u, u squared, u cubed and cubic term g = 4*u3 - 4*u, clamped
    assign s2_u     = qscale(r_s1_pu);
    assign s3_u2    = qscale(r_s2_pu2);
    assign s4_u3    = qscale(r_s3_pu3);
    assign s4_gdiff = ((DATA_W+3)'(s4_u3) <<< 2) - ((DATA_W+3)'(r_s3_u) <<< 2);

    // stage 6: potential slope plus tilt
    assign s6_p    = qscale(r_s5_pp);
    assign s6_ssum = (DATA_W+1)'(s6_p) + (DATA_W+1)'(r_asymmetry);
    assign s6_s    = sat32(PROD_W'(s6_ssum));

    // stage 7: force is the negated slope
    assign s7_q   = qscale(r_s6_pq);
    assign s7_neg = -((DATA_W+1)'(s7_q));
    assign s7_f   = sat32(PROD_W'(s7_neg));

    // stage 8: drift
    assign s8_drift = qscale(r_s7_pd);

    // stage 9: half-distance reflection off the lower then the upper wall
    assign s9_y0 = (DATA_W+5)'(r_s8_y);
    assign s9_lo = (DATA_W+5)'(r_lower_bound);
    assign s9_hi = (DATA_W+5)'(r_upper_bound);

    always_comb begin
        if (s9_y0 < s9_lo) begin
            s9_y1 = s9_lo + ((s9_lo - s9_y0) >>> 1);
        end else begin
            s9_y1 = s9_y0;
        end
        if (s9_y1 > s9_hi) begin
            s9_y2 = s9_hi - ((s9_y1 - s9_hi) >>> 1);
        end else begin
            s9_y2 = s9_y1;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        // stage 1: u and kick products
        r_s1_pu   <= mul_su(i_position, r_inv_length);
        r_s1_pk   <= mul_su(i_noise_sample, r_noise_scale);
        r_s1_x    <= i_position;
        // stage 2: u squared
        r_s2_pu2  <= mul_ss(s2_u, s2_u);
        r_s2_u    <= s2_u;
        r_s2_kick <= qscale(r_s1_pk);
        r_s2_x    <= r_s1_x;
        // stage 3: u cubed
        r_s3_pu3  <= mul_ss(s3_u2, r_s2_u);
        r_s3_u    <= r_s2_u;
        r_s3_kick <= r_s2_kick;
        r_s3_x    <= r_s2_x;
        // stage 4: cubic term
        r_s4_g    <= sat32(PROD_W'(s4_gdiff));
        r_s4_kick <= r_s3_kick;
        r_s4_x    <= r_s3_x;
        // stage 5: depth scaling
        r_s5_pp   <= mul_su(r_s4_g, r_depth_scale);
        r_s5_kick <= r_s4_kick;
        r_s5_x    <= r_s4_x;
        // stage 6: slope times inverse length
        r_s6_pq   <= mul_su(s6_s, r_inv_length);
        r_s6_kick <= r_s5_kick;
        r_s6_x    <= r_s5_x;
        // stage 7: force times time step
        r_s7_pd   <= mul_su(s7_f, r_time_step);
        r_s7_kick <= r_s6_kick;
        r_s7_x    <= r_s6_x;
        // stage 8: raw new position
        r_s8_y    <= (DATA_W+2)'(r_s7_x) + (DATA_W+2)'(s8_drift) + (DATA_W+2)'(r_s7_kick);
        // stage 9: reflected and clamped
        r_s9_out  <= sat32(PROD_W'(s9_y2));
    end

    assign o_valid        = r_vld[PIPE_DEPTH];
    assign o_new_position = r_s9_out;

`ifndef SYNTH
    // every request yields a result strobe
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##9 o_valid)
        else $error("result strobe missing after request");

    // no result without a request at the matching cycle
    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 9))
        else $error("result strobe without matching request");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");
`endif

endmodule

`default_nettype wire
